// File: hdl/per_core_voltage_max_governor_assert.svh
// assertion macros for the per-core voltage max governor
`ifndef PER_CORE_VOLTAGE_MAX_GOVERNOR_ASSERT_SVH
`define PER_CORE_VOLTAGE_MAX_GOVERNOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PCVMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcvmg assertion failed");
`define PCVMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcvmg assertion failed");
`else
`define PCVMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PCVMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/pcvmg_pkg.sv
// shared constants and types for the per-core voltage max governor
package pcvmg_pkg;

    localparam int CORES         = 8;
    localparam int CORE_W        = $clog2(CORES);
    localparam int VOLT_W        = 12;
    localparam int FIELD_W       = 11;
    localparam int CNT_W         = 32;
    localparam int OUTCOME_W     = 3;

    localparam int NOMINAL_INT   = 4000;
    localparam int KERNEL_DROP   = 111;
    localparam int KERNEL_INT    = (NOMINAL_INT >= KERNEL_DROP) ? NOMINAL_INT - KERNEL_DROP : 0;

    localparam logic [VOLT_W-1:0] NOMINAL_LEVEL = VOLT_W'(NOMINAL_INT);
    localparam logic [VOLT_W-1:0] KERNEL_LEVEL  = VOLT_W'(KERNEL_INT);
    localparam logic [VOLT_W-1:0] FIELD_BASE    = VOLT_W'(2048);

    localparam logic [OUTCOME_W-1:0] OUT_RAISE         = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_LOWER         = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_SKIP_FAST     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_SKIP_SLOW     = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_DISABLED      = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_ABOVE_NOMINAL = 3'd5;

    typedef struct packed {
        logic load_in;
        logic scan_start;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [VOLT_W-1:0]    vdd_level;
        logic                 regulator_write;
        logic [VOLT_W-1:0]    voltage_offset;
        logic [FIELD_W-1:0]   offset_field;
        logic                 must_wait_rise;
        logic [CNT_W-1:0]     raise_total;
        logic [CNT_W-1:0]     lower_total;
        logic [CNT_W-1:0]     fast_skip_total;
        logic [CNT_W-1:0]     slow_skip_total;
    } result_t;

endpackage

// File: hdl/pcvmg_ifs.sv
// channel interfaces: switch events, results and the enable register write
interface pcvmg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  core_index;
    logic [11:0] requested_voltage;

    modport source (output valid, output core_index, output requested_voltage, input ready);
    modport sink   (input valid, input core_index, input requested_voltage, output ready);
endinterface

interface pcvmg_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [11:0] vdd_level;
    logic        regulator_write;
    logic [11:0] voltage_offset;
    logic [10:0] offset_field;
    logic        must_wait_rise;
    logic [31:0] raise_total;
    logic [31:0] lower_total;
    logic [31:0] fast_skip_total;
    logic [31:0] slow_skip_total;

    modport source (
        output valid, output outcome, output vdd_level, output regulator_write,
        output voltage_offset, output offset_field, output must_wait_rise,
        output raise_total, output lower_total, output fast_skip_total,
        output slow_skip_total, input ready
    );
    modport sink (
        input valid, input outcome, input vdd_level, input regulator_write,
        input voltage_offset, input offset_field, input must_wait_rise,
        input raise_total, input lower_total, input fast_skip_total,
        input slow_skip_total, output ready
    );
endinterface

interface pcvmg_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, output enable, input ready);
    modport sink   (input valid, input enable, output ready);
endinterface

// File: hdl/pcvmg_ctrl.sv
// sequencing state machine: accept, evaluate, table scan, commit
`include "per_core_voltage_max_governor_assert.svh"

module pcvmg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pcvmg_pkg::dp_status_t  sts,
    output pcvmg_pkg::ctrl_cmd_t   cmd
);
    import pcvmg_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PCVMG_ASSERT_NEXT(a_scan_ends, clk, rst_n, state_reg == ST_SCAN && sts.scan_last, state_reg == ST_FINISH)
    `PCVMG_ASSERT_NEXT(a_finish_holds, clk, rst_n, state_reg == ST_FINISH && !sts.out_free, state_reg == ST_FINISH)
    `PCVMG_ASSERT_NEXT(a_idle_exit, clk, rst_n, state_reg == ST_IDLE, state_reg == ST_IDLE || state_reg == ST_EVAL)

endmodule

// File: hdl/pcvmg_dp.sv
// datapath: request table, max scan, voltage decision, counters, result register
`include "per_core_voltage_max_governor_assert.svh"

module pcvmg_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_enable,
    input  logic [2:0]               core_index,
    input  logic [11:0]              requested_voltage,
    input  pcvmg_pkg::ctrl_cmd_t     cmd,
    output pcvmg_pkg::dp_status_t    sts,
    pcvmg_out_if.source              result
);
    import pcvmg_pkg::*;

    logic                 enable_reg;
    logic [VOLT_W-1:0]    table_reg [CORES];
    logic [VOLT_W-1:0]    req_reg;
    logic [VOLT_W-1:0]    cur_reg;
    logic [VOLT_W-1:0]    max_reg;
    logic [CORE_W-1:0]    idx_reg;
    logic [CNT_W-1:0]     raise_reg;
    logic [CNT_W-1:0]     lower_reg;
    logic [CNT_W-1:0]     fast_reg;
    logic [CNT_W-1:0]     slow_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic [VOLT_W-1:0]    cur_next;
    logic [CNT_W-1:0]     raise_next;
    logic [CNT_W-1:0]     lower_next;
    logic [CNT_W-1:0]     fast_next;
    logic [CNT_W-1:0]     slow_next;
    logic [VOLT_W-1:0]    entry;
    logic [VOLT_W-1:0]    chosen;
    logic [VOLT_W-1:0]    offset;
    logic [VOLT_W-1:0]    field_diff;
    logic                 have_choice;
    result_t              out_next;

    assign entry         = table_reg[idx_reg];
    assign sts.need_scan = enable_reg && (req_reg < cur_reg);
    assign sts.scan_last = (idx_reg == CORE_W'(CORES - 1));
    assign sts.out_free  = !out_valid_reg || result.ready;

    // decision made once the scan (if any) has settled
    always_comb
    begin
        cur_next    = cur_reg;
        raise_next  = raise_reg;
        lower_next  = lower_reg;
        fast_next   = fast_reg;
        slow_next   = slow_reg;
        chosen      = req_reg;
        have_choice = 1'b0;
        out_next    = '0;
        out_next.outcome = OUT_DISABLED;
        if (enable_reg)
        begin
            if (req_reg == cur_reg)
            begin
                fast_next        = fast_reg + 1'b1;
                out_next.outcome = OUT_SKIP_FAST;
            end
            else if (req_reg > cur_reg)
            begin
                raise_next       = raise_reg + 1'b1;
                have_choice      = 1'b1;
                out_next.outcome = OUT_RAISE;
            end
            else if (max_reg == cur_reg)
            begin
                slow_next        = slow_reg + 1'b1;
                out_next.outcome = OUT_SKIP_SLOW;
            end
            else if (max_reg < cur_reg)
            begin
                lower_next       = lower_reg + 1'b1;
                chosen           = max_reg;
                have_choice      = 1'b1;
                out_next.outcome = OUT_LOWER;
            end
            else
            begin
                // scan found something higher: a rise that no counter records
                chosen           = max_reg;
                have_choice      = 1'b1;
                out_next.outcome = OUT_RAISE;
            end
            if (have_choice)
            begin
                if (chosen > NOMINAL_LEVEL)
                begin
                    out_next.outcome = OUT_ABOVE_NOMINAL;
                end
                else
                begin
                    cur_next                 = chosen;
                    out_next.regulator_write = 1'b1;
                    out_next.must_wait_rise  = (chosen > cur_reg);
                end
            end
        end
        offset     = (cur_next <= NOMINAL_LEVEL) ? NOMINAL_LEVEL - cur_next : '0;
        field_diff = FIELD_BASE - offset;
        out_next.vdd_level         = cur_next;
        out_next.voltage_offset    = offset;
        out_next.offset_field      = (offset != '0) ? field_diff[FIELD_W-1:0] : '0;
        out_next.raise_total       = raise_next;
        out_next.lower_total       = lower_next;
        out_next.fast_skip_total   = fast_next;
        out_next.slow_skip_total   = slow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            cur_reg       <= NOMINAL_LEVEL;
            raise_reg     <= '0;
            lower_reg     <= '0;
            fast_reg      <= '0;
            slow_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CORES; i++)
            begin
                table_reg[i] <= KERNEL_LEVEL;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_enable;
            end
            if (cmd.load_in && enable_reg)
            begin
                table_reg[core_index] <= requested_voltage;
            end
            if (cmd.commit)
            begin
                cur_reg   <= cur_next;
                raise_reg <= raise_next;
                lower_reg <= lower_next;
                fast_reg  <= fast_next;
                slow_reg  <= slow_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= requested_voltage;
        end
        if (cmd.scan_start)
        begin
            max_reg <= req_reg;
            idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            max_reg <= (entry > max_reg) ? entry : max_reg;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.outcome           = out_reg.outcome;
    assign result.vdd_level         = out_reg.vdd_level;
    assign result.regulator_write   = out_reg.regulator_write;
    assign result.voltage_offset    = out_reg.voltage_offset;
    assign result.offset_field      = out_reg.offset_field;
    assign result.must_wait_rise    = out_reg.must_wait_rise;
    assign result.raise_total       = out_reg.raise_total;
    assign result.lower_total       = out_reg.lower_total;
    assign result.fast_skip_total   = out_reg.fast_skip_total;
    assign result.slow_skip_total   = out_reg.slow_skip_total;

    `PCVMG_ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, !out_valid_reg || result.ready)
    `PCVMG_ASSERT_IMPL(a_cur_bounded, clk, rst_n, 1'b1, cur_reg <= NOMINAL_LEVEL)
    `PCVMG_ASSERT_IMPL(a_wait_needs_write, clk, rst_n, out_valid_reg && !out_reg.regulator_write, !out_reg.must_wait_rise)

endmodule

// File: hdl/per_core_voltage_max_governor.sv
// top level of the per-core voltage max governor
// flow: a beat accepted on switch_evt is evaluated; when a lower request triggers the
//   table scan, the scan runs first; then the result is committed into the result register
// a new beat is accepted only once the previous result is committed; the scan reads the
//   eight-entry request table one entry per cycle
// reset: rst_n asynchronous active low; table to kernel level, voltage to nominal,
//   counters zero, enable off, result channel empty
module per_core_voltage_max_governor (
    input  logic        clk,
    input  logic        rst_n,
    pcvmg_cfg_if.sink   cfg,
    pcvmg_in_if.sink    switch_evt,
    pcvmg_out_if.source result
);
    import pcvmg_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    logic       evt_ready;

    // cfg is always ready, so the source must write the enable register only while idle
    assign cfg.ready        = 1'b1;
    assign switch_evt.ready = evt_ready;

    // controller: idle -> evaluate -> (scan) -> commit into the result register
    pcvmg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (switch_evt.valid),
        .in_ready (evt_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: holds all datapath state and the registered result beat
    pcvmg_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg.valid),
        .cfg_enable        (cfg.enable),
        .core_index        (switch_evt.core_index),
        .requested_voltage (switch_evt.requested_voltage),
        .cmd               (cmd),
        .sts               (sts),
        .result            (result)
    );

endmodule
